// ===== rtl/zth_pkg.sv =====
// ----------------------------------------------------------------------------
// zth_pkg: shared types and constants for the tile hash core
// Holds the request kinds, the fixed field widths and the bit-mixing helpers.
// ----------------------------------------------------------------------------
package zth_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned TIDX_W  = 10;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ROT_W   = 6;
  // position, color, table_index, table_word, padded to whole bytes
  localparam int unsigned IN_DATA_W = 104;

  localparam logic [HASH_W-1:0] EVEN_MASK = 64'h5555_5555_5555_5555;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_TOGGLE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  // Rotate left: upper half of the doubled word shifted left.
  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v,
                                             input logic [ROT_W-1:0] d);
    logic [2*HASH_W-1:0] dbl;
    dbl = {v, v} << d;
    return dbl[2*HASH_W-1:HASH_W];
  endfunction

  // Rotate right: lower half of the doubled word shifted right.
  function automatic logic [HASH_W-1:0] rotr(input logic [HASH_W-1:0] v,
                                             input logic [ROT_W-1:0] d);
    logic [2*HASH_W-1:0] dbl;
    dbl = {v, v} >> d;
    return dbl[HASH_W-1:0];
  endfunction

  // Even bits go left, odd bits go right, by the same amount.
  function automatic logic [HASH_W-1:0] mix_word(input logic [HASH_W-1:0] w,
                                                 input logic [ROT_W-1:0] d);
    return rotl(w & EVEN_MASK, d) | rotr(w & ~EVEN_MASK, d);
  endfunction

endpackage

// ===== rtl/zobrist_tile_hash_core.sv =====
// A word accepted at the input waits in stage 1 for its table read, then
// retires into the output register once that register is free or emptied.
// Throughput: one word per cycle while the result side keeps up; the table
// RAM has one read and one write port; each retiring word updates the hash.
// Reset (rst, synchronous, active high) clears the running hash and the
// pipeline valids. The table is not cleared and is undefined until loaded.
// ----------------------------------------------------------------------------
// zobrist_tile_hash_core: running 64-bit tile hash over a random word table
// Load words fill the table, toggle words XOR a mixed table word into the
// hash, clear words zero it; every word returns the hash after it.
// ----------------------------------------------------------------------------
module zobrist_tile_hash_core #(
  parameter int unsigned SLOT_COUNT = 4  // position slots, power of two 1..256
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: position[15:0], color[23:16], table_index[33:24],
  //        table_word[97:34], zero pad[103:98]
  input  logic [zth_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [zth_pkg::REQ_W-1:0]      s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: hash_value[63:0]
  output logic [zth_pkg::HASH_W-1:0]     m_axis_tdata
);

  import zth_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned DEPTH  = SLOT_COUNT * 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // Unpack the request word.
  logic [POS_W-1:0]   position;
  logic [COLOR_W-1:0] color;
  logic [TIDX_W-1:0]  table_index;
  logic [HASH_W-1:0]  table_word;
  req_t               req;

  assign position    = s_axis_tdata[15:0];
  assign color       = s_axis_tdata[23:16];
  assign table_index = s_axis_tdata[33:24];
  assign table_word  = s_axis_tdata[97:34];
  assign req         = req_t'(s_axis_tuser);

  // Stage 0: address generation. The low position bits select the slot, the
  // rest form the wrap count, which offsets the color byte inside the slot.
  logic [POS_W-1:0]   pos_slot;
  logic [POS_W-1:0]   wrap;
  logic [COLOR_W-1:0] word_byte;
  logic [ADDR_W-1:0]  toggle_addr;
  logic [ADDR_W-1:0]  load_addr;

  assign pos_slot    = position & POS_W'(SLOT_COUNT - 1);
  assign wrap        = position >> SLOT_W;
  assign word_byte   = color + wrap[COLOR_W-1:0];
  assign toggle_addr = ADDR_W'({pos_slot, word_byte});
  // Load addresses wrap at the table size.
  assign load_addr   = ADDR_W'(table_index);

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Stage 1 holds the request kind and rotate amount while the RAM read
  // completes. A load written at one edge is seen by a toggle read at the
  // next edge, so back-to-back load then toggle needs no forwarding.
  logic              s1_valid;
  req_t              s1_req;
  logic [ROT_W-1:0]  s1_rot;
  logic [HASH_W-1:0] rd_word;
  logic              s1_go;

  // Stage 1 retires into the output register when that register is free
  // or being emptied this cycle.
  assign s1_go         = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_go;

  // The read is enabled only on accept, so the RAM output holds while
  // stage 1 waits on a stalled output.
  zth_ram #(
    .WIDTH (HASH_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (accept && (req == REQ_LOAD)),
    .waddr (load_addr),
    .wdata (table_word),
    .re    (accept && (req == REQ_TOGGLE)),
    .raddr (toggle_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
      s1_rot <= wrap[ROT_W-1:0];
    end
  end

  // Hash update: the running hash lives in one register, updated in order.
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] hash_next;

  always_comb begin
    case (s1_req)
      REQ_TOGGLE: hash_next = hash ^ mix_word(rd_word, s1_rot);
      REQ_CLEAR:  hash_next = '0;
      default:    hash_next = hash;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (s1_go) begin
      hash <= hash_next;
    end
  end

  // Output register: parts the result side from the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      m_axis_tdata <= hash_next;
    end
  end

  // The word shown is always the running hash after the last retired item.
  assert property (@(posedge clk) disable iff (rst)
    s1_go |=> (m_axis_tdata == hash))
    else $error("result word differs from running hash");

  // A retired clear returns zero.
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_req == REQ_CLEAR)) |=> (m_axis_tdata == '0))
    else $error("clear did not return zero");

  // A waiting stage 1 keeps its item and rotate amount.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_rot) && $stable(s1_req)))
    else $error("stalled stage 1 lost its item");

endmodule

// ===== rtl/zth_ram.sv =====
// ----------------------------------------------------------------------------
// zth_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module zth_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tile hash core
// Drives load, toggle, clear and unused request words into the core. A
// scoreboard keeps its own table and running hash and compares each returned
// hash word, in order, against its prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import zth_pkg::*;

  localparam int unsigned N_POS       = 4;
  localparam int unsigned SLOT_BITS   = $clog2(N_POS);
  localparam int unsigned TABLE_DEPTH = 256 * N_POS;
  // The request field is two bits wide, and the core has no kind for code 3.
  // Such words must leave the hash alone and still return it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Number of cycles without any accepted word before the run is aborted.
  localparam int unsigned STALL_LIMIT = 2000;
  // Length of the deliberate result-side hold-off.
  localparam int unsigned HOLD_CYCLES = 80;
  // Margin kept after the final drain so a stray extra result would be caught.
  localparam int unsigned TAIL_CYCLES = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [HASH_W-1:0]     m_axis_tdata;

  // Shared between the stimulus thread and the result-side ready generator.
  bit steady;            // when set, neither side inserts idle cycles
  int unsigned hold_requests;

  // Entries that the stimulus has loaded; toggles only ever aim at these.
  bit loaded [TABLE_DEPTH];
  int unsigned loaded_list[$];

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the table and the running hash, plus the
  // queue of hash words that the core still owes us.
  // --------------------------------------------------------------------------
  class hash_scoreboard;
    logic [HASH_W-1:0] tile_table [TABLE_DEPTH];
    logic [HASH_W-1:0] running_hash;
    logic [HASH_W-1:0] owed_hashes[$];
    int unsigned       errors;

    function new();
      running_hash = '0;
      errors       = 0;
    endfunction

    // Picks the table word for a tile and spins its even bits left and its
    // odd bits right by the wrap count.
    function logic [HASH_W-1:0] tile_key(logic [POS_W-1:0] pos,
                                         logic [COLOR_W-1:0] color);
      int unsigned slot, wrap, entry, amt;
      logic [HASH_W-1:0] w, ev, od;
      slot  = pos & (N_POS - 1);
      wrap  = pos >> SLOT_BITS;
      entry = slot * 256 + ((color + wrap) & 255);
      w     = tile_table[entry % TABLE_DEPTH];
      amt   = wrap % 64;
      if (amt == 0) begin
        return w;
      end
      ev = w & {32{2'b01}};
      od = w & {32{2'b10}};
      return (ev << amt) | (ev >> (64 - amt)) | (od >> amt) | (od << (64 - amt));
    endfunction

    // Called for every request word the core takes.
    function void note_request(logic [REQ_W-1:0] kind, logic [IN_DATA_W-1:0] data);
      logic [POS_W-1:0]   pos;
      logic [COLOR_W-1:0] color;
      logic [TIDX_W-1:0]  tidx;
      logic [HASH_W-1:0]  word;
      pos   = data[15:0];
      color = data[23:16];
      tidx  = data[33:24];
      word  = data[97:34];
      case (kind)
        REQ_LOAD: begin
          tile_table[tidx % TABLE_DEPTH] = word;
        end
        REQ_TOGGLE: begin
          running_hash = running_hash ^ tile_key(pos, color);
        end
        REQ_CLEAR: begin
          running_hash = '0;
        end
        default: begin
        end
      endcase
      owed_hashes.push_back(running_hash);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    // Called for every hash word the core hands over.
    task check_result(logic [HASH_W-1:0] got);
      logic [HASH_W-1:0] want;
      if (owed_hashes.size() == 0) begin
        report_mismatch($sformatf("hash_value %h with no request pending", got));
      end else begin
        want = owed_hashes.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("hash_value got %h expected %h", got, want));
        end
      end
    endtask

    function int unsigned pending();
      return owed_hashes.size();
    endfunction
  endclass

  hash_scoreboard hash_sb = new();

  // --------------------------------------------------------------------------
  // Device under test.
  // --------------------------------------------------------------------------
  zobrist_tile_hash_core #(
    .SLOT_COUNT(N_POS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor. Both streams are sampled in the active region right after the
  // rising edge, so they show the values the core saw at that edge. The
  // request is noted before the result is checked, so a same-edge result can
  // never be flagged as unexpected by accident.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        hash_sb.note_request(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        hash_sb.check_result(m_axis_tdata);
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result-side ready. Normally low on about 11 percent of edges. When the
  // stimulus asks for a hold-off, this process keeps ready low on its own
  // for the HOLD_CYCLES hold-off so the core fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // --------------------------------------------------------------------------
  // Request driving. Every task is entered right after a rising edge and
  // returns right after the edge at which its word was taken, so tvalid gets
  // at most one assignment per time step.
  // --------------------------------------------------------------------------
  task send_word(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                 logic [COLOR_W-1:0] color, logic [TIDX_W-1:0] tidx,
                 logic [HASH_W-1:0] word);
    if (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, word, tidx, color, pos};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // A load; position and color carry junk since the core must ignore them.
  task load_entry(int unsigned entry, logic [HASH_W-1:0] word);
    int unsigned slot_entry;
    slot_entry = entry % TABLE_DEPTH;
    send_word(REQ_LOAD, POS_W'($urandom), COLOR_W'($urandom), TIDX_W'(entry), word);
    if (!loaded[slot_entry]) begin
      loaded[slot_entry] = 1'b1;
      loaded_list.push_back(slot_entry);
    end
  endtask

  // A toggle aimed at a loaded entry: the slot comes from the entry, the
  // wrap count is given, and the color is chosen so that color plus wrap
  // lands on the entry's byte.
  task toggle_entry(int unsigned entry, int unsigned wrap);
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
    pos   = POS_W'((wrap << SLOT_BITS) | (entry / 256));
    color = COLOR_W'((entry % 256) - wrap);
    send_word(REQ_TOGGLE, pos, color, TIDX_W'($urandom), {$urandom, $urandom});
  endtask

  // Lowers tvalid and waits until every owed hash word has come back.
  task drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (hash_sb.pending() != 0);
  endtask

  localparam int unsigned WRAP_MAX = (1 << (POS_W - SLOT_BITS)) - 1;

  initial begin
    int unsigned roll;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_LOAD;
    steady        = 1'b0;
    hold_requests = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The unused code and a clear come first, on a fresh hash,
    // with every data bit set so they show nothing leaks from the fields.
    send_word(REQ_UNUSED, '1, '1, '1, '1);
    send_word(REQ_CLEAR, '1, '1, '1, '1);
    load_entry(0, 64'hFFFF_FFFF_FFFF_FFFF);
    load_entry(TABLE_DEPTH - 1, 64'hAAAA_AAAA_AAAA_AAAA);
    load_entry(255, 64'h8000_0000_0000_0001);
    load_entry(256, 64'h0123_4567_89AB_CDEF);
    load_entry(768, 64'h5555_5555_5555_5555);
    load_entry(512, 64'h0);
    toggle_entry(0, 0);                    // lowest position and color
    toggle_entry(255, 0);                  // color 255 with no wrap
    toggle_entry(TABLE_DEPTH - 1, WRAP_MAX); // position all ones, largest spin
    toggle_entry(256, 1);                  // single-bit spin
    toggle_entry(768, 64);                 // wrap count is a multiple of 64
    toggle_entry(512, 33);                 // an all-zero word changes nothing
    // A load followed at once by a toggle that reads the same entry.
    load_entry(0, {$urandom, $urandom});
    toggle_entry(0, 5);
    send_word(REQ_UNUSED, POS_W'($urandom), COLOR_W'($urandom), TIDX_W'($urandom),
              {$urandom, $urandom});
    send_word(REQ_CLEAR, POS_W'($urandom), COLOR_W'($urandom), TIDX_W'($urandom),
              {$urandom, $urandom});
    toggle_entry(TABLE_DEPTH - 1, 32);
    load_entry(TABLE_DEPTH - 1, {$urandom, $urandom});
    toggle_entry(TABLE_DEPTH - 1, WRAP_MAX);
    toggle_entry(255, 63);

    // Random part: mostly toggles over loaded entries, with loads that grow
    // and overwrite the table, some clears and some unused codes.
    for (int n = 0; n < 600; n++) begin
      if (n == 150) begin
        hold_requests++;
      end
      if (n == 300) begin
        drain();
      end
      steady = (n >= 350 && n < 450);
      roll = $urandom_range(99);
      if (roll < 25) begin
        if ($urandom_range(2) == 0) begin
          load_entry(loaded_list[$urandom_range(loaded_list.size() - 1)],
                     {$urandom, $urandom});
        end else begin
          load_entry($urandom_range(TABLE_DEPTH - 1), {$urandom, $urandom});
        end
      end else if (roll < 85) begin
        toggle_entry(loaded_list[$urandom_range(loaded_list.size() - 1)],
                     $urandom_range(WRAP_MAX));
      end else if (roll < 93) begin
        send_word(REQ_CLEAR, POS_W'($urandom), COLOR_W'($urandom), TIDX_W'($urandom),
                  {$urandom, $urandom});
      end else begin
        send_word(REQ_UNUSED, POS_W'($urandom), COLOR_W'($urandom), TIDX_W'($urandom),
                  {$urandom, $urandom});
      end
    end
    steady = 1'b0;

    // Wait for the last hash words, then a little longer so that a stray
    // extra result would still be caught.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (hash_sb.pending() != 0) begin
      hash_sb.report_mismatch($sformatf("%0d hash words never arrived",
                                        hash_sb.pending()));
    end
    if (hash_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
